@@ sv/hls_pkg.sv @@
// hls_pkg: shared types and codes for the handshake link sender.
// Used by hls_front, hls_jobq, hls_back and handshake_link_sender_unit.
`default_nettype none
package hls_pkg;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_EDGE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] KIND_RESET = 3'd0;
  localparam logic [2:0] KIND_UART  = 3'd1;
  localparam logic [2:0] KIND_SPI   = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_FAIL  = 3'd4;
  localparam logic [2:0] KIND_BUSY  = 3'd5;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAXFAIL = 2'd1;
  localparam logic [1:0] REG_ENDBYTE = 2'd2;
  localparam logic [1:0] REG_IGNBYTE = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd800;
  localparam logic [3:0]  MAXFAIL_RESET = 4'd3;
  localparam logic [4:0]  FAIL_SAT      = 5'd31;
  localparam logic [4:0]  FAIL_CREDIT   = 5'd2;

  typedef enum logic [2:0] {
    ST_NOLINK  = 3'd0,
    ST_BOOT    = 3'd1,
    ST_IDLE    = 3'd2,
    ST_HEADER  = 3'd3,
    ST_PAYLOAD = 3'd4
  } link_state_t;

  typedef enum logic [2:0] {
    JOB_RESET      = 3'd0,
    JOB_BUSY       = 3'd1,
    JOB_HEADER     = 3'd2,
    JOB_SPI        = 3'd3,
    JOB_DONE       = 3'd4,
    JOB_CLEAR      = 3'd5,
    JOB_RESET_FAIL = 3'd6
  } job_code_t;

  typedef struct packed {
    logic [1:0] command;
    logic [8:0] frame_length;
    logic       handshake_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] uart_byte;
    logic [8:0] spi_length;
    logic       notify_level;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  max_fail;
    logic [7:0]  end_byte;
    logic [7:0]  ignore_byte;
  } cfg_t;

  typedef struct packed {
    job_code_t  code;
    logic [7:0] hdr_lo;
    logic [7:0] hdr_hi;
    logic [8:0] length;
    logic       notify;
  } job_t;

endpackage
`default_nettype wire

@@ sv/hls_front.sv @@
// hls_front: accepts events, keeps the link state and classifies each event
// into at most one job for the back end. Depends on hls_pkg.
`default_nettype none
module hls_front import hls_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t in_item,
  input  wire cfg_t     cfg,
  output logic          job_valid,
  output job_t          job
);

  link_state_t link_state, link_state_next;
  logic [4:0]  fail_count, fail_count_next;
  logic [15:0] wait_timer, wait_timer_next;
  logic [8:0]  held_length, held_length_next;
  logic        send_waiting, send_waiting_next;

  logic [15:0] tick_sum;
  logic        timed_out;
  logic [4:0]  fail_inc;
  logic        fail_over;
  logic        waiting;

  assign waiting   = (link_state inside {ST_HEADER, ST_PAYLOAD});
  assign tick_sum  = wait_timer + 16'd1;
  assign timed_out = (tick_sum >= cfg.timeout_ticks);
  assign fail_inc  = (fail_count < FAIL_SAT) ? fail_count + 5'd1 : fail_count;
  assign fail_over = (fail_inc > {1'b0, cfg.max_fail});

  always_comb begin
    link_state_next   = link_state;
    fail_count_next   = fail_count;
    wait_timer_next   = wait_timer;
    held_length_next  = held_length;
    send_waiting_next = send_waiting;
    if (accept) begin
      case (in_item.command)
        CMD_SEND: begin
          if (link_state == ST_NOLINK) begin
            held_length_next  = in_item.frame_length;
            send_waiting_next = 1'b1;
            link_state_next   = ST_BOOT;
          end else if (link_state == ST_IDLE) begin
            held_length_next = in_item.frame_length;
            link_state_next  = ST_HEADER;
            wait_timer_next  = '0;
          end
        end
        CMD_EDGE: begin
          if (!in_item.handshake_level && link_state == ST_HEADER) begin
            fail_count_next = (fail_count > FAIL_CREDIT) ? fail_count - FAIL_CREDIT : '0;
            link_state_next = ST_PAYLOAD;
            wait_timer_next = '0;
          end else if (in_item.handshake_level && link_state == ST_PAYLOAD) begin
            link_state_next = ST_IDLE;
          end else if (in_item.handshake_level && link_state == ST_BOOT) begin
            link_state_next = ST_IDLE;
            if (send_waiting) begin
              send_waiting_next = 1'b0;
              link_state_next   = ST_HEADER;
              wait_timer_next   = '0;
            end
          end
        end
        CMD_TICK: begin
          if (waiting) begin
            wait_timer_next = tick_sum;
            if (timed_out) begin
              wait_timer_next = '0;
              if (link_state == ST_HEADER) begin
                if (fail_over) begin
                  fail_count_next   = '0;
                  send_waiting_next = 1'b0;
                  link_state_next   = ST_BOOT;
                end else begin
                  fail_count_next = fail_inc;
                  link_state_next = ST_IDLE;
                end
              end else begin
                send_waiting_next = 1'b0;
                link_state_next   = ST_BOOT;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // header word: length, parity of odd-index bits, parity of even-index bits, overall parity
  always_comb begin
    job_valid   = 1'b0;
    job.code    = JOB_BUSY;
    job.hdr_lo  = held_length_next[7:0];
    job.hdr_hi  = {4'd0, ^held_length_next,
                   ^{held_length_next[0], held_length_next[2], held_length_next[4],
                     held_length_next[6], held_length_next[8]},
                   ^{held_length_next[1], held_length_next[3], held_length_next[5],
                     held_length_next[7]},
                   held_length_next[8]};
    job.length  = held_length_next;
    job.notify  = (link_state_next == ST_PAYLOAD);
    if (accept) begin
      case (in_item.command)
        CMD_SEND: begin
          job_valid = 1'b1;
          if (link_state == ST_NOLINK) begin
            job.code = JOB_RESET;
          end else if (link_state == ST_IDLE) begin
            job.code = JOB_HEADER;
          end else begin
            job.code = JOB_BUSY;
          end
        end
        CMD_EDGE: begin
          if (!in_item.handshake_level && link_state == ST_HEADER) begin
            job_valid = 1'b1;
            job.code  = JOB_SPI;
          end else if (in_item.handshake_level && link_state == ST_PAYLOAD) begin
            job_valid = 1'b1;
            job.code  = JOB_DONE;
          end else if (in_item.handshake_level && link_state == ST_BOOT && send_waiting) begin
            job_valid = 1'b1;
            job.code  = JOB_HEADER;
          end
        end
        CMD_TICK: begin
          if (waiting && timed_out) begin
            job_valid = 1'b1;
            if (link_state == ST_HEADER && !fail_over) begin
              job.code = JOB_CLEAR;
            end else begin
              job.code = JOB_RESET_FAIL;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_state   <= ST_NOLINK;
      fail_count   <= '0;
      wait_timer   <= '0;
      held_length  <= '0;
      send_waiting <= 1'b0;
    end else begin
      link_state   <= link_state_next;
      fail_count   <= fail_count_next;
      wait_timer   <= wait_timer_next;
      held_length  <= held_length_next;
      send_waiting <= send_waiting_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/hls_jobq.sv @@
// hls_jobq: short register queue of jobs between front and back end.
// Depends on hls_pkg.
`default_nettype none
module hls_jobq import hls_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  output job_t      rd_job,
  output logic      empty,
  input  wire logic rd_en
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full   = (count == FULL_CNT);
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/hls_back.sv @@
// hls_back: expands each job into its result items and loads them into the
// output register, one per cycle unless the receiver stalls. Depends on hls_pkg.
`default_nettype none
module hls_back import hls_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire job_t job,
  input  wire logic job_empty,
  output logic      job_pop,
  output out_item_t out_item,
  output logic      out_valid,
  input  wire logic pop
);

  logic [2:0] step;
  logic [2:0] last_step;
  logic       advance;
  out_item_t  item;

  assign advance = !job_empty && (!out_valid || pop);
  assign job_pop = advance && item.last;

  always_comb begin
    case (job.code)
      JOB_HEADER:     last_step = 3'd2;
      JOB_CLEAR:      last_step = 3'd4;
      JOB_RESET_FAIL: last_step = 3'd1;
      default:        last_step = 3'd0;
    endcase
  end

  always_comb begin
    item.kind         = KIND_BUSY;
    item.uart_byte    = '0;
    item.spi_length   = '0;
    item.notify_level = job.notify;
    item.last         = (step == last_step);
    case (job.code)
      JOB_RESET: item.kind = KIND_RESET;
      JOB_BUSY:  item.kind = KIND_BUSY;
      JOB_SPI: begin
        item.kind       = KIND_SPI;
        item.spi_length = job.length;
      end
      JOB_DONE:  item.kind = KIND_DONE;
      JOB_HEADER: begin
        item.kind = KIND_UART;
        case (step)
          3'd0:    item.uart_byte = job.hdr_lo;
          3'd1:    item.uart_byte = job.hdr_hi;
          default: item.uart_byte = cfg.end_byte;
        endcase
      end
      JOB_CLEAR: begin
        if (step == 3'd4) begin
          item.kind = KIND_FAIL;
        end else begin
          item.kind      = KIND_UART;
          item.uart_byte = (step == 3'd0) ? cfg.ignore_byte : cfg.end_byte;
        end
      end
      JOB_RESET_FAIL: item.kind = (step == 3'd0) ? KIND_RESET : KIND_FAIL;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= item.last ? 3'd0 : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/handshake_link_sender_unit.sv @@
// handshake_link_sender_unit: top level of the link sender; holds the
// configuration registers. Depends on hls_pkg, hls_front, hls_jobq, hls_back.
//
// Usage:
//   Events enter as a queue write: in_item is taken when push is high and
//   full is low. Results leave as a queue read: out_item is valid while
//   empty is low and is consumed when pop is high.
//   Configuration: cfg_index/cfg_data are written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Path: after the event transfer, the first result of an event passes
//   through the job queue write and then the output register.
//   Flow: one event per cycle into the job queue while full is low; the
//   back end emits one result per cycle unless the receiver stalls. A job
//   yields 1 to 5 results (header 3, clear sequence 5). full rises when
//   JOB_DEPTH jobs wait. Events that produce no result take no queue slot.
//   Reset: link state is no link, counters cleared, queues empty,
//   registers back to timeout 800, max fail 3, end and ignore bytes 0.
//   Receiver stall: the output register holds its item; the back end stops,
//   the job queue fills and then full holds off new events.
`default_nettype none
module handshake_link_sender_unit import hls_pkg::*; #(
  parameter int JOB_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t      cfg;
  logic      accept;
  logic      job_valid;
  job_t      job_in;
  job_t      job_head;
  logic      job_empty;
  logic      job_pop;
  logic      out_valid;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.max_fail      <= MAXFAIL_RESET;
      cfg.end_byte      <= '0;
      cfg.ignore_byte   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        REG_MAXFAIL: cfg.max_fail      <= cfg_data[3:0];
        REG_ENDBYTE: cfg.end_byte      <= cfg_data[7:0];
        REG_IGNBYTE: cfg.ignore_byte   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  hls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job_in)
  );

  hls_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job_in),
    .full   (full),
    .rd_job (job_head),
    .empty  (job_empty),
    .rd_en  (job_pop)
  );

  hls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (job_head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_item  (out_item),
    .out_valid (out_valid),
    .pop       (pop)
  );

  a_uart_only_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.kind != KIND_UART) |-> (out_item.uart_byte == 8'd0))
    else $error("uart_byte set on a non-uart result");

  a_spi_only_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.kind != KIND_SPI) |-> (out_item.spi_length == 9'd0))
    else $error("spi_length set on a non-spi result");

  a_spi_notify: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.kind == KIND_SPI) |-> out_item.notify_level)
    else $error("spi start without notify");

  a_done_notify: assert property (@(posedge clk) disable iff (rst)
    (!empty && (out_item.kind == KIND_DONE || out_item.kind == KIND_RESET))
      |-> !out_item.notify_level)
    else $error("notify high after transfer end");

endmodule
`default_nettype wire

@@ tb/handshake_link_sender_unit_tb.sv @@
// handshake_link_sender_unit_tb: self-checking bench for the link sender; predicts every result
// from accepted events and compares each popped result field by field.
// Depends on hls_pkg and handshake_link_sender_unit.
`timescale 1ns / 1ps
module handshake_link_sender_unit_tb;
  import hls_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  class link_result_board;
    link_state_t st;
    logic [4:0]  fails;
    logic [15:0] wait_ticks;
    logic [8:0]  held_len;
    bit          send_pending;
    logic [15:0] timeout_ticks;
    logic [3:0]  max_fail;
    logic [7:0]  end_byte;
    logic [7:0]  ignore_byte;
    out_item_t   owed[$];
    out_item_t   batch[$];
    int          mismatches;
    int          useful_events;

    function new();
      st = ST_NOLINK;
      fails = '0;
      wait_ticks = '0;
      held_len = '0;
      send_pending = 1'b0;
      timeout_ticks = TIMEOUT_RESET;
      max_fail = MAXFAIL_RESET;
      end_byte = '0;
      ignore_byte = '0;
      mismatches = 0;
      useful_events = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_TIMEOUT: timeout_ticks = val;
        REG_MAXFAIL: max_fail = val[3:0];
        REG_ENDBYTE: end_byte = val[7:0];
        REG_IGNBYTE: ignore_byte = val[7:0];
        default: ;
      endcase
    endfunction

    function void add(logic [2:0] kind, logic [7:0] data, logic [8:0] len);
      out_item_t r;
      r = '0;
      r.kind = kind;
      r.uart_byte = data;
      r.spi_length = len;
      batch.push_back(r);
    endfunction

    function void send_header();
      logic [11:0] w;
      w = {^held_len,
           ^{held_len[8], held_len[6], held_len[4], held_len[2], held_len[0]},
           ^{held_len[7], held_len[5], held_len[3], held_len[1]},
           held_len};
      add(KIND_UART, w[7:0], '0);
      add(KIND_UART, {4'd0, w[11:8]}, '0);
      add(KIND_UART, end_byte, '0);
      st = ST_HEADER;
      wait_ticks = '0;
    endfunction

    function void note_event(in_item_t ev);
      link_state_t st0;
      logic [15:0] t0;
      st0 = st;
      t0 = wait_ticks;
      batch.delete();
      case (ev.command)
        CMD_SEND: begin
          if (st == ST_NOLINK) begin
            held_len = ev.frame_length;
            send_pending = 1'b1;
            st = ST_BOOT;
            add(KIND_RESET, '0, '0);
          end else if (st == ST_IDLE) begin
            held_len = ev.frame_length;
            send_header();
          end else begin
            add(KIND_BUSY, '0, '0);
          end
        end
        CMD_EDGE: begin
          if (!ev.handshake_level && st == ST_HEADER) begin
            fails = (fails > FAIL_CREDIT) ? fails - FAIL_CREDIT : '0;
            st = ST_PAYLOAD;
            wait_ticks = '0;
            add(KIND_SPI, '0, held_len);
          end else if (ev.handshake_level && st == ST_PAYLOAD) begin
            st = ST_IDLE;
            add(KIND_DONE, '0, '0);
          end else if (ev.handshake_level && st == ST_BOOT) begin
            st = ST_IDLE;
            if (send_pending) begin
              send_pending = 1'b0;
              send_header();
            end
          end
        end
        CMD_TICK: begin
          if (st == ST_HEADER || st == ST_PAYLOAD) begin
            wait_ticks = wait_ticks + 16'd1;
            if (wait_ticks >= timeout_ticks) begin
              wait_ticks = '0;
              if (st == ST_HEADER) begin
                if (fails < FAIL_SAT) fails = fails + 5'd1;
                if (fails > {1'b0, max_fail}) begin
                  fails = '0;
                  send_pending = 1'b0;
                  st = ST_BOOT;
                  add(KIND_RESET, '0, '0);
                end else begin
                  add(KIND_UART, ignore_byte, '0);
                  add(KIND_UART, end_byte, '0);
                  add(KIND_UART, end_byte, '0);
                  add(KIND_UART, end_byte, '0);
                  st = ST_IDLE;
                end
              end else begin
                send_pending = 1'b0;
                st = ST_BOOT;
                add(KIND_RESET, '0, '0);
              end
              add(KIND_FAIL, '0, '0);
            end
          end
        end
        default: ;
      endcase
      foreach (batch[i]) begin
        batch[i].notify_level = (st == ST_PAYLOAD);
        batch[i].last = (i == batch.size() - 1);
        owed.push_back(batch[i]);
      end
      if (batch.size() != 0 || st != st0 || wait_ticks != t0) useful_events++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display(
            "%0t: result with nothing expected: kind=%0d uart=%02h spi=%0d notify=%0b last=%0b",
            $realtime, got.kind, got.uart_byte, got.spi_length, got.notify_level, got.last);
        return;
      end
      exp = owed.pop_front();
      if (got.kind !== exp.kind || got.uart_byte !== exp.uart_byte ||
          got.spi_length !== exp.spi_length || got.notify_level !== exp.notify_level ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch: expected kind=%0d uart=%02h spi=%0d notify=%0b last=%0b",
                   $realtime, exp.kind, exp.uart_byte, exp.spi_length, exp.notify_level,
                   exp.last);
          $display("%0t:           actual   kind=%0d uart=%02h spi=%0d notify=%0b last=%0b",
                   $realtime, got.kind, got.uart_byte, got.spi_length, got.notify_level,
                   got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  link_result_board sb;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;

  handshake_link_sender_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (!empty && pop) sb.check_result(out_item);
      if (push && !full) sb.note_event(in_item);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t ev_of(logic [1:0] cmd, logic [8:0] len, logic lvl);
    in_item_t e;
    e.command = cmd;
    e.frame_length = len;
    e.handshake_level = lvl;
    return e;
  endfunction

  // mostly protocol-correct events for the current link state, some noise
  function automatic in_item_t pick_event();
    in_item_t e;
    int r;
    r = $urandom_range(99);
    e.frame_length = $urandom_range(511);
    e.handshake_level = $urandom_range(1);
    e.command = $urandom_range(3);
    case (sb.st)
      ST_NOLINK, ST_IDLE: begin
        if (r < 75) e.command = CMD_SEND;
      end
      ST_BOOT: begin
        if (r < 70) begin
          e.command = CMD_EDGE;
          e.handshake_level = 1'b1;
        end
      end
      ST_HEADER: begin
        if (r < 55) begin
          e.command = CMD_EDGE;
          e.handshake_level = 1'b0;
        end else if (r < 85) begin
          e.command = CMD_TICK;
        end
      end
      default: begin
        if (r < 55) begin
          e.command = CMD_EDGE;
          e.handshake_level = 1'b1;
        end else if (r < 85) begin
          e.command = CMD_TICK;
        end
      end
    endcase
    return e;
  endfunction

  task automatic push_event(input bit pick, input in_item_t fixed);
    in_item_t e;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    e = pick ? pick_event() : fixed;
    push <= 1'b1;
    in_item <= e;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_TIMEOUT, c.timeout_ticks);
    write_reg(REG_MAXFAIL, {12'd0, c.max_fail});
    write_reg(REG_ENDBYTE, {8'd0, c.end_byte});
    write_reg(REG_IGNBYTE, {8'd0, c.ignore_byte});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input cfg_t c, input int idle, input int stall,
                           input in_item_t fixed_items[$], input int n_random,
                           input bit pressure);
    int k;
    int goal;
    drain_results();
    program_regs(c);
    idle_pct = idle;
    stall_pct = stall;
    foreach (fixed_items[i]) push_event(1'b0, fixed_items[i]);
    goal = sb.useful_events + n_random;
    k = 0;
    while (sb.useful_events < goal) begin
      if (pressure && k == 30) hold_req = 1'b1;
      if (pressure && k == 80) drain_results();
      push_event(1'b1, '0);
      k++;
    end
  endtask

  function automatic cfg_t cfg_of(logic [15:0] tmo, logic [3:0] maxf, logic [7:0] endb,
                                  logic [7:0] ignb);
    cfg_t c;
    c.timeout_ticks = tmo;
    c.max_fail = maxf;
    c.end_byte = endb;
    c.ignore_byte = ignb;
    return c;
  endfunction

  initial begin
    in_item_t dir_a[$];
    in_item_t dir_b[$];
    in_item_t none[$];
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    cycle_count = 0;

    // no link, boot, header timeout to reset, payload, payload timeout
    dir_a = '{ev_of(CMD_EDGE, 9'd0, 1'b1), ev_of(CMD_TICK, 9'd0, 1'b0),
              ev_of(CMD_UNUSED, 9'h1FF, 1'b1), ev_of(CMD_SEND, 9'h1FF, 1'b0),
              ev_of(CMD_SEND, 9'd0, 1'b0), ev_of(CMD_EDGE, 9'd0, 1'b0),
              ev_of(CMD_TICK, 9'd0, 1'b0), ev_of(CMD_EDGE, 9'd0, 1'b1),
              ev_of(CMD_TICK, 9'd0, 1'b0), ev_of(CMD_EDGE, 9'd0, 1'b1),
              ev_of(CMD_SEND, 9'd0, 1'b1), ev_of(CMD_EDGE, 9'd0, 1'b1),
              ev_of(CMD_EDGE, 9'd0, 1'b0), ev_of(CMD_SEND, 9'h0F0, 1'b0),
              ev_of(CMD_EDGE, 9'd0, 1'b0), ev_of(CMD_EDGE, 9'd0, 1'b1),
              ev_of(CMD_SEND, 9'h155, 1'b0), ev_of(CMD_EDGE, 9'd0, 1'b0),
              ev_of(CMD_TICK, 9'd0, 1'b0), ev_of(CMD_EDGE, 9'd0, 1'b1),
              ev_of(CMD_SEND, 9'h0AA, 1'b1)};
    // header timeouts that send the clear sequence
    dir_b = '{ev_of(CMD_TICK, 9'd0, 1'b0), ev_of(CMD_SEND, 9'h100, 1'b0),
              ev_of(CMD_TICK, 9'h1FF, 1'b1), ev_of(CMD_EDGE, 9'd0, 1'b0),
              ev_of(CMD_TICK, 9'd0, 1'b0)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_phase(cfg_of(16'd0, 4'd0, 8'hFF, 8'h00), 21, 21, dir_a, 0, 1'b0);
    run_phase(cfg_of(16'd1, 4'd15, 8'h00, 8'hFF), 21, 21, dir_b, 0, 1'b0);
    run_phase(cfg_of(16'd3, 4'd3, 8'($urandom_range(255)), 8'($urandom_range(255))),
              0, 0, none, 100, 1'b0);
    run_phase(cfg_of(16'd1, 4'd0, 8'($urandom_range(255)), 8'($urandom_range(255))),
              54, 0, none, 100, 1'b0);
    run_phase(cfg_of(16'd2, 4'd15, 8'($urandom_range(255)), 8'($urandom_range(255))),
              0, 54, none, 100, 1'b1);
    run_phase(cfg_of(16'd5, 4'd7, 8'($urandom_range(255)), 8'($urandom_range(255))),
              21, 21, none, 70, 1'b0);
    run_phase(cfg_of(16'hFFFF, 4'd15, 8'hFF, 8'hFF), 0, 0, none, 30, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
